// File: sv/ssplit_pkg.sv
// shared types, character codes and lexer helpers for the sql statement splitter
package ssplit_pkg;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;

  // lexer mode
  typedef enum logic [1:0] {
    LEX_NORMAL = 2'd0,
    LEX_STRING = 2'd1,
    LEX_LINE   = 2'd2,
    LEX_BLOCK  = 2'd3
  } lex_t;

  // byte held back until the next one decides its meaning
  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_DASH  = 2'd1,
    HOLD_SLASH = 2'd2,
    HOLD_QUOTE = 2'd3
  } hold_t;

  // result kind on the output channel
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END     = 2'd1,
    KIND_STR_ERR = 2'd2,
    KIND_BLK_ERR = 2'd3
  } kind_t;

  // final action of one input beat
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_EMIT    = 3'd1,
    ACT_SPACE   = 3'd2,
    ACT_CLOSE   = 3'd3,
    ACT_ERR_STR = 3'd4,
    ACT_ERR_BLK = 3'd5
  } act_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FLUSH = 2'd1,
    ST_HELD  = 2'd2,
    ST_ACT   = 2'd3
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic flush_beat;
    logic held_beat;
    logic act_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic plan_pre;
    act_t plan_act;
    logic pre_l;
    act_t act_l;
    logic act_out_l;
    logic count_nz;
    logic flush_last;
    logic out_free;
  } sts_t;

  // plain-text handling of one byte
  typedef struct packed {
    act_t  act;
    hold_t held;
    logic  to_string;
  } np_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

  function automatic np_t normal_plan(input logic [7:0] c);
    np_t r;
    r.act       = ACT_NONE;
    r.held      = HOLD_NONE;
    r.to_string = 1'b0;
    if (c == CH_QUOTE) begin
      r.act       = ACT_EMIT;
      r.to_string = 1'b1;
    end else if (c == CH_DASH) begin
      r.held = HOLD_DASH;
    end else if (c == CH_SLASH) begin
      r.held = HOLD_SLASH;
    end else if (c == CH_SEMI) begin
      r.act = ACT_CLOSE;
    end else if (is_space(c)) begin
      r.act = ACT_SPACE;
    end else begin
      r.act = ACT_EMIT;
    end
    return r;
  endfunction

endpackage

// File: sv/sql_statement_splitter_core.sv
// sql statement splitter: removes comments, trims whitespace, splits on semicolons
// each beat is accepted, then takes a step per buffered whitespace byte it flushes, a
// step for a held dash or slash sent first and a step for its final action (whitespace,
// byte, semicolon, end of text); result steps also wait for a free output register
// a result shows on the output in the cycle after the step that makes it
// reset is synchronous and active low; the whitespace buffer is not cleared
module sql_statement_splitter_core #(
  parameter int SPACE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] space_dropped, [15:9] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  ssplit_pkg::cmd_t cmd;
  ssplit_pkg::sts_t sts;
  logic [7:0]       obyte;
  logic             odrop;

  // sequencing
  ssplit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // lexer, buffer and output register
  ssplit_dp #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_tdata),
    .in_eot      (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (out_tuser),
    .out_byte    (obyte),
    .out_dropped (odrop),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'b0, odrop, obyte};

endmodule

// File: sv/ssplit_ctrl.sv
// controller state machine sequencing whitespace flush, held byte and final action
module ssplit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ssplit_pkg::sts_t  sts,
  output ssplit_pkg::cmd_t  cmd
);

  ssplit_pkg::state_t state_r;
  ssplit_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssplit_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssplit_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if ((sts.plan_pre || sts.plan_act == ssplit_pkg::ACT_EMIT) && sts.count_nz) begin
            state_nxt = ssplit_pkg::ST_FLUSH;
          end else if (sts.plan_pre) begin
            state_nxt = ssplit_pkg::ST_HELD;
          end else if (sts.plan_act != ssplit_pkg::ACT_NONE) begin
            state_nxt = ssplit_pkg::ST_ACT;
          end
        end
      end
      ssplit_pkg::ST_FLUSH: begin
        if (sts.out_free && sts.flush_last) begin
          state_nxt = sts.pre_l ? ssplit_pkg::ST_HELD : ssplit_pkg::ST_ACT;
        end
      end
      ssplit_pkg::ST_HELD: begin
        if (sts.out_free) begin
          state_nxt = (sts.act_l == ssplit_pkg::ACT_NONE) ? ssplit_pkg::ST_IDLE
                                                          : ssplit_pkg::ST_ACT;
        end
      end
      ssplit_pkg::ST_ACT: begin
        if (!sts.act_out_l || sts.out_free) begin
          state_nxt = ssplit_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssplit_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    in_tready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.flush_beat = 1'b0;
    cmd.held_beat  = 1'b0;
    cmd.act_step   = 1'b0;
    case (state_r)
      ssplit_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ssplit_pkg::ST_FLUSH: begin
        cmd.flush_beat = sts.out_free;
      end
      ssplit_pkg::ST_HELD: begin
        cmd.held_beat = sts.out_free;
      end
      ssplit_pkg::ST_ACT: begin
        cmd.act_step = !sts.act_out_l || sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/ssplit_dp.sv
// datapath: lexer state, whitespace buffer and output register
module ssplit_dp #(
  parameter int SPACE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  logic              in_eot,
  input  ssplit_pkg::cmd_t  cmd,
  output ssplit_pkg::sts_t  sts,
  input  logic              out_tready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte,
  output logic              out_dropped,
  output logic              out_last
);

  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);

  // lexer state
  ssplit_pkg::lex_t  lex_r, lex_nxt;
  ssplit_pkg::hold_t held_r, held_nxt;
  logic              star_r, star_nxt;
  logic              open_r, open_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              over_r, over_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;

  // latched plan of the current beat
  logic              pre_r;
  logic [7:0]        pre_byte_r;
  ssplit_pkg::act_t  act_r;
  logic              act_out_r;
  logic [7:0]        byte_r;

  // plan of the incoming beat
  logic              plan_pre;
  logic [7:0]        plan_pre_byte;
  ssplit_pkg::act_t  plan_act;
  logic              plan_act_out;
  ssplit_pkg::np_t   np;

  // whitespace buffer
  logic [7:0]        mem [SPACE_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [1:0]        okind_nxt;
  logic [7:0]        obyte_nxt;
  logic              odrop_nxt;
  logic              olast_nxt;
  logic [1:0]        okind_r;
  logic [7:0]        obyte_r;
  logic              odrop_r;
  logic              olast_r;

  logic [CW-1:0]     idx_inc;
  logic              out_free;

  assign idx_inc  = idx_r + CW'(1);
  assign out_free = !out_valid_r || out_tready;

  // decode the incoming beat
  always_comb begin
    np            = ssplit_pkg::normal_plan(in_byte);
    plan_pre      = 1'b0;
    plan_pre_byte = (held_r == ssplit_pkg::HOLD_SLASH) ? ssplit_pkg::CH_SLASH
                                                       : ssplit_pkg::CH_DASH;
    plan_act      = ssplit_pkg::ACT_NONE;
    lex_nxt       = lex_r;
    held_nxt      = ssplit_pkg::HOLD_NONE;
    star_nxt      = star_r;
    if (in_eot) begin
      plan_pre = (lex_r == ssplit_pkg::LEX_NORMAL) &&
                 (held_r == ssplit_pkg::HOLD_DASH || held_r == ssplit_pkg::HOLD_SLASH);
      case (lex_r)
        ssplit_pkg::LEX_STRING: begin
          plan_act = (held_r == ssplit_pkg::HOLD_QUOTE) ? ssplit_pkg::ACT_CLOSE
                                                        : ssplit_pkg::ACT_ERR_STR;
        end
        ssplit_pkg::LEX_BLOCK: plan_act = ssplit_pkg::ACT_ERR_BLK;
        default:               plan_act = ssplit_pkg::ACT_CLOSE;
      endcase
      lex_nxt  = ssplit_pkg::LEX_NORMAL;
      star_nxt = 1'b0;
    end else begin
      case (lex_r)
        ssplit_pkg::LEX_NORMAL: begin
          if (held_r == ssplit_pkg::HOLD_DASH && in_byte == ssplit_pkg::CH_DASH) begin
            lex_nxt = ssplit_pkg::LEX_LINE;
          end else if (held_r == ssplit_pkg::HOLD_SLASH &&
                       in_byte == ssplit_pkg::CH_STAR) begin
            lex_nxt  = ssplit_pkg::LEX_BLOCK;
            star_nxt = 1'b0;
          end else begin
            plan_pre = (held_r == ssplit_pkg::HOLD_DASH) ||
                       (held_r == ssplit_pkg::HOLD_SLASH);
            plan_act = np.act;
            held_nxt = np.held;
            if (np.to_string) begin
              lex_nxt = ssplit_pkg::LEX_STRING;
            end
          end
        end
        ssplit_pkg::LEX_STRING: begin
          if (held_r == ssplit_pkg::HOLD_QUOTE) begin
            if (in_byte == ssplit_pkg::CH_QUOTE) begin
              plan_act = ssplit_pkg::ACT_EMIT;
            end else begin
              lex_nxt  = np.to_string ? ssplit_pkg::LEX_STRING : ssplit_pkg::LEX_NORMAL;
              plan_act = np.act;
              held_nxt = np.held;
            end
          end else begin
            plan_act = ssplit_pkg::ACT_EMIT;
            if (in_byte == ssplit_pkg::CH_QUOTE) begin
              held_nxt = ssplit_pkg::HOLD_QUOTE;
            end
          end
        end
        ssplit_pkg::LEX_LINE: begin
          if (in_byte == ssplit_pkg::CH_NL) begin
            lex_nxt  = ssplit_pkg::LEX_NORMAL;
            plan_act = ssplit_pkg::ACT_SPACE;
          end
        end
        default: begin
          if (star_r && in_byte == ssplit_pkg::CH_SLASH) begin
            lex_nxt  = ssplit_pkg::LEX_NORMAL;
            star_nxt = 1'b0;
          end else begin
            star_nxt = (in_byte == ssplit_pkg::CH_STAR);
          end
        end
      endcase
    end
  end

  // does the final action put out a result
  always_comb begin
    case (plan_act)
      ssplit_pkg::ACT_EMIT,
      ssplit_pkg::ACT_ERR_STR,
      ssplit_pkg::ACT_ERR_BLK: plan_act_out = 1'b1;
      ssplit_pkg::ACT_CLOSE:   plan_act_out = open_r || plan_pre;
      default:                 plan_act_out = 1'b0;
    endcase
  end

  // buffer bookkeeping and result selection
  always_comb begin
    open_nxt      = open_r;
    count_nxt     = count_r;
    over_nxt      = over_r;
    idx_nxt       = idx_r;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    okind_nxt     = ssplit_pkg::KIND_BYTE;
    obyte_nxt     = 8'h00;
    odrop_nxt     = 1'b0;
    olast_nxt     = 1'b0;
    if (cmd.accept) begin
      idx_nxt = '0;
    end
    if (cmd.flush_beat) begin
      out_load  = 1'b1;
      obyte_nxt = rd_data_r;
      odrop_nxt = over_r;
      idx_nxt   = idx_inc;
    end
    if (cmd.held_beat) begin
      out_load  = 1'b1;
      obyte_nxt = pre_byte_r;
      odrop_nxt = over_r;
      olast_nxt = !act_out_r;
      count_nxt = '0;
      over_nxt  = 1'b0;
      open_nxt  = 1'b1;
    end
    if (cmd.act_step) begin
      case (act_r)
        ssplit_pkg::ACT_EMIT: begin
          out_load  = 1'b1;
          obyte_nxt = byte_r;
          odrop_nxt = over_r;
          olast_nxt = 1'b1;
          count_nxt = '0;
          over_nxt  = 1'b0;
          open_nxt  = 1'b1;
        end
        ssplit_pkg::ACT_SPACE: begin
          if (open_r) begin
            if (count_r < DEPTH_C) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              over_nxt = 1'b1;
            end
          end
        end
        ssplit_pkg::ACT_CLOSE: begin
          out_load  = open_r;
          okind_nxt = ssplit_pkg::KIND_END;
          olast_nxt = 1'b1;
          count_nxt = '0;
          over_nxt  = 1'b0;
          open_nxt  = 1'b0;
        end
        ssplit_pkg::ACT_ERR_STR,
        ssplit_pkg::ACT_ERR_BLK: begin
          out_load  = 1'b1;
          okind_nxt = (act_r == ssplit_pkg::ACT_ERR_STR) ? ssplit_pkg::KIND_STR_ERR
                                                         : ssplit_pkg::KIND_BLK_ERR;
          olast_nxt = 1'b1;
          count_nxt = '0;
          over_nxt  = 1'b0;
          open_nxt  = 1'b0;
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_r       <= ssplit_pkg::LEX_NORMAL;
      held_r      <= ssplit_pkg::HOLD_NONE;
      star_r      <= 1'b0;
      open_r      <= 1'b0;
      count_r     <= '0;
      over_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        lex_r  <= lex_nxt;
        held_r <= held_nxt;
        star_r <= star_nxt;
      end
      open_r      <= open_nxt;
      count_r     <= count_nxt;
      over_r      <= over_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // latched plan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r     <= 1'b0;
      act_r     <= ssplit_pkg::ACT_NONE;
      act_out_r <= 1'b0;
    end else if (cmd.accept) begin
      pre_r     <= plan_pre;
      act_r     <= plan_act;
      act_out_r <= plan_act_out;
    end
  end

  // latched bytes
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r     <= in_byte;
      pre_byte_r <= plan_pre_byte;
    end
  end

  // whitespace buffer, read data follows the next flush index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= byte_r;
    end
    rd_data_r <= mem[idx_nxt[AW-1:0]];
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      okind_r <= okind_nxt;
      obyte_r <= obyte_nxt;
      odrop_r <= odrop_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = okind_r;
  assign out_byte    = obyte_r;
  assign out_dropped = odrop_r;
  assign out_last    = olast_r;

  assign sts.plan_pre   = plan_pre;
  assign sts.plan_act   = plan_act;
  assign sts.pre_l      = pre_r;
  assign sts.act_l      = act_r;
  assign sts.act_out_l  = act_out_r;
  assign sts.count_nz   = (count_r != '0);
  assign sts.flush_last = (idx_inc == count_r);
  assign sts.out_free   = out_free;

  // buffer fill never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("whitespace count beyond buffer depth");

  // dropped bytes only once the buffer is full
  a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    over_r |-> (count_r == DEPTH_C))
    else $error("overflow mark with buffer not full");

  // a flush beat only reads written entries
  a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_beat |-> (idx_r < count_r))
    else $error("flush read beyond buffer fill");

  // a held byte is always a dash or a slash
  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.held_beat |-> (pre_byte_r == ssplit_pkg::CH_DASH ||
                       pre_byte_r == ssplit_pkg::CH_SLASH))
    else $error("held beat with unexpected byte");

endmodule

// File: tb/sv/tb_sql_statement_splitter_core.sv
// testbench for the sql statement splitter: directed rows, then random sql-like text
module tb_sql_statement_splitter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WS_DEPTH = 16;

  // one result beat as the splitter should give it
  typedef struct packed {
    ssplit_pkg::kind_t kind;
    logic [7:0]        ch;
    logic              dropped;
    logic              last;
  } result_t;

  // one directed row; want is used only where typed is set
  typedef struct packed {
    logic              mode;
    logic [7:0]        ch;
    logic              typed;
    ssplit_pkg::kind_t kind;
    logic [7:0]        want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    '{1'b0, 8'h41,               1'b1, ssplit_pkg::KIND_BYTE,    8'h41},   // first byte after reset
    '{1'b0, ssplit_pkg::CH_SP,    1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, 8'h00,               1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // zero byte flushes the space
    '{1'b0, ssplit_pkg::CH_QUOTE, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // string opens
    '{1'b0, ssplit_pkg::CH_QUOTE, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_QUOTE, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // doubled quote stays literal
    '{1'b0, 8'hFF,               1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_QUOTE, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_SEMI,  1'b1, ssplit_pkg::KIND_END,     8'h00},   // string closes, statement ends
    '{1'b0, ssplit_pkg::CH_DASH,  1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_DASH,  1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // line comment
    '{1'b0, 8'h7F,               1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_NL,    1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // leading whitespace dropped
    '{1'b0, ssplit_pkg::CH_TAB,   1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_SLASH, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_STAR,  1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // block comment
    '{1'b0, ssplit_pkg::CH_STAR,  1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_SLASH, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_DASH,  1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b1, 8'h00,               1'b0, ssplit_pkg::KIND_BYTE,    8'h00},   // held dash at end of text
    '{1'b0, ssplit_pkg::CH_QUOTE, 1'b1, ssplit_pkg::KIND_BYTE,    ssplit_pkg::CH_QUOTE},
    '{1'b1, 8'hFF,               1'b1, ssplit_pkg::KIND_STR_ERR, 8'h00},   // open string at end of text
    '{1'b0, ssplit_pkg::CH_SLASH, 1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b0, ssplit_pkg::CH_STAR,  1'b0, ssplit_pkg::KIND_BYTE,    8'h00},
    '{1'b1, 8'h00,               1'b1, ssplit_pkg::KIND_BLK_ERR, 8'h00}    // open block comment at end
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] text_byte
  logic        in_tuser = 1'b0;    // [0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] out_byte, [8] space_dropped, [15:9] zero
  logic [1:0]  out_tuser;          // [1:0] kind
  logic        out_tlast;

  logic        calm = 1'b0;
  int          text_beats = 0;
  int          mismatches = 0;
  result_t     expected_results[$];

  // splitter state mirrored by the predictor
  ssplit_pkg::lex_t  lx;
  ssplit_pkg::hold_t held;
  logic        star_pending;
  logic        stmt_open;
  logic [7:0]  ws_buf [WS_DEPTH];
  int          ws_len;
  logic        ws_over;
  result_t     step_res[$];

  sql_statement_splitter_core #(
    .SPACE_DEPTH(WS_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // receiver stalls now and then, never inside the calm stretch
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 8);
  end

  function automatic logic ws_char(input logic [7:0] c);
    return (c == ssplit_pkg::CH_SP) || (c == ssplit_pkg::CH_TAB) ||
           (c == ssplit_pkg::CH_NL) || (c == ssplit_pkg::CH_CR) ||
           (c == ssplit_pkg::CH_FF) || (c == ssplit_pkg::CH_VT);
  endfunction

  function automatic void put(input ssplit_pkg::kind_t k, input logic [7:0] c, input logic d);
    result_t r;
    r = '{kind: k, ch: c, dropped: d, last: 1'b0};
    step_res.insert(step_res.size(), r);
  endfunction

  // a visible byte releases the waiting whitespace run first
  function automatic void send_char(input logic [7:0] c);
    logic d;
    d = ws_over;
    for (int i = 0; i < ws_len; i++) put(ssplit_pkg::KIND_BYTE, ws_buf[i], d);
    ws_len = 0;
    ws_over = 1'b0;
    put(ssplit_pkg::KIND_BYTE, c, d);
    stmt_open = 1'b1;
  endfunction

  function automatic void keep_space(input logic [7:0] c);
    if (!stmt_open) return;
    if (ws_len < WS_DEPTH) begin
      ws_buf[ws_len] = c;
      ws_len++;
    end else begin
      ws_over = 1'b1;
    end
  endfunction

  // trailing run is thrown away, end mark only for a non-empty statement
  function automatic void end_statement();
    ws_len = 0;
    ws_over = 1'b0;
    if (stmt_open) put(ssplit_pkg::KIND_END, 8'h00, 1'b0);
    stmt_open = 1'b0;
  endfunction

  function automatic void plain_byte(input logic [7:0] c);
    if (c == ssplit_pkg::CH_QUOTE) begin
      send_char(c);
      lx = ssplit_pkg::LEX_STRING;
    end else if (c == ssplit_pkg::CH_DASH) begin
      held = ssplit_pkg::HOLD_DASH;
    end else if (c == ssplit_pkg::CH_SLASH) begin
      held = ssplit_pkg::HOLD_SLASH;
    end else if (c == ssplit_pkg::CH_SEMI) begin
      end_statement();
    end else if (ws_char(c)) begin
      keep_space(c);
    end else begin
      send_char(c);
    end
  endfunction

  function automatic void clear_state();
    lx = ssplit_pkg::LEX_NORMAL;
    held = ssplit_pkg::HOLD_NONE;
    star_pending = 1'b0;
    stmt_open = 1'b0;
    ws_len = 0;
    ws_over = 1'b0;
  endfunction

  // results of one input beat, left in step_res
  function automatic void splitter_step(input logic m, input logic [7:0] c);
    step_res.delete();
    if (m) begin
      if (lx == ssplit_pkg::LEX_NORMAL && held == ssplit_pkg::HOLD_DASH)
        send_char(ssplit_pkg::CH_DASH);
      else if (lx == ssplit_pkg::LEX_NORMAL && held == ssplit_pkg::HOLD_SLASH)
        send_char(ssplit_pkg::CH_SLASH);
      else if (lx == ssplit_pkg::LEX_STRING && held == ssplit_pkg::HOLD_QUOTE)
        lx = ssplit_pkg::LEX_NORMAL;
      held = ssplit_pkg::HOLD_NONE;
      if (lx == ssplit_pkg::LEX_STRING) put(ssplit_pkg::KIND_STR_ERR, 8'h00, 1'b0);
      else if (lx == ssplit_pkg::LEX_BLOCK) put(ssplit_pkg::KIND_BLK_ERR, 8'h00, 1'b0);
      else end_statement();
      clear_state();
    end else begin
      case (lx)
        ssplit_pkg::LEX_NORMAL: begin
          if (held == ssplit_pkg::HOLD_DASH && c == ssplit_pkg::CH_DASH) begin
            held = ssplit_pkg::HOLD_NONE;
            lx = ssplit_pkg::LEX_LINE;
          end else if (held == ssplit_pkg::HOLD_SLASH && c == ssplit_pkg::CH_STAR) begin
            held = ssplit_pkg::HOLD_NONE;
            lx = ssplit_pkg::LEX_BLOCK;
            star_pending = 1'b0;
          end else begin
            if (held == ssplit_pkg::HOLD_DASH) send_char(ssplit_pkg::CH_DASH);
            else if (held == ssplit_pkg::HOLD_SLASH) send_char(ssplit_pkg::CH_SLASH);
            held = ssplit_pkg::HOLD_NONE;
            plain_byte(c);
          end
        end
        ssplit_pkg::LEX_STRING: begin
          if (held == ssplit_pkg::HOLD_QUOTE) begin
            held = ssplit_pkg::HOLD_NONE;
            if (c == ssplit_pkg::CH_QUOTE) begin
              send_char(c);
            end else begin
              lx = ssplit_pkg::LEX_NORMAL;
              plain_byte(c);
            end
          end else begin
            send_char(c);
            held = (c == ssplit_pkg::CH_QUOTE) ? ssplit_pkg::HOLD_QUOTE : ssplit_pkg::HOLD_NONE;
          end
        end
        ssplit_pkg::LEX_LINE: begin
          held = ssplit_pkg::HOLD_NONE;
          if (c == ssplit_pkg::CH_NL) begin
            lx = ssplit_pkg::LEX_NORMAL;
            keep_space(c);
          end
        end
        default: begin
          held = ssplit_pkg::HOLD_NONE;
          if (star_pending && c == ssplit_pkg::CH_SLASH) begin
            lx = ssplit_pkg::LEX_NORMAL;
            star_pending = 1'b0;
          end else begin
            star_pending = (c == ssplit_pkg::CH_STAR);
          end
        end
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_space();
    logic [7:0] set [6];
    set = '{ssplit_pkg::CH_SP, ssplit_pkg::CH_TAB, ssplit_pkg::CH_NL,
            ssplit_pkg::CH_CR, ssplit_pkg::CH_FF, ssplit_pkg::CH_VT};
    return set[$urandom_range(0, 5)];
  endfunction

  // one input beat; called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic m, input logic [7:0] c,
                           input logic typed = 1'b0, input result_t typed_res = '0);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    splitter_step(m, c);
    if (typed) expected_results.insert(expected_results.size(), typed_res);
    else foreach (step_res[i]) expected_results.insert(expected_results.size(), step_res[i]);
    text_beats++;
    @(negedge clk);
  endtask

  // sender holds off until every expected beat is out
  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, got kind %0d byte %0h",
                 $time, out_tuser, out_tdata[7:0]);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("out_byte", want.ch, out_tdata[7:0]);
        check_field("space_dropped", want.dropped, out_tdata[8]);
        check_field("last_of_run", want.last, out_tlast);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    result_t    row_res;
    logic [7:0] c;
    int         n;
    int         pick;
    logic       paused_once;

    paused_once = 1'b0;
    clear_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    foreach (DIRECTED[i]) begin
      row_res = '{kind: DIRECTED[i].kind, ch: DIRECTED[i].want, dropped: 1'b0, last: 1'b1};
      send_beat(DIRECTED[i].mode, DIRECTED[i].ch, DIRECTED[i].typed, row_res);
    end
    drain_wait();

    // random sql-like text, mostly well formed tokens
    text_beats = 0;
    while (text_beats < 355) begin
      calm = (text_beats >= 120) && (text_beats < 220);
      if (!paused_once && text_beats >= 200) begin
        drain_wait();
        paused_once = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // word
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) c = 8'h30 + 8'($urandom_range(0, 9));
          else c = 8'h41 + 8'($urandom_range(0, 25)) + 8'($urandom_range(0, 1) * 32);
          send_beat(1'b0, c);
        end
      end else if (pick < 48) begin
        // whitespace run, sometimes past the buffer depth
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 3);
        repeat (n) send_beat(1'b0, pick_space());
      end else if (pick < 58) begin
        // quoted string with random content
        send_beat(1'b0, ssplit_pkg::CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          send_beat(1'b0, c);
          if (c == ssplit_pkg::CH_QUOTE && $urandom_range(0, 3) != 0)
            send_beat(1'b0, ssplit_pkg::CH_QUOTE);
        end
        send_beat(1'b0, ssplit_pkg::CH_QUOTE);
        if ($urandom_range(0, 4) == 0) send_beat(1'b0, ssplit_pkg::CH_QUOTE);
      end else if (pick < 64) begin
        // line comment, now and then cut off by end of text
        send_beat(1'b0, ssplit_pkg::CH_DASH);
        send_beat(1'b0, ssplit_pkg::CH_DASH);
        n = $urandom_range(0, 8);
        repeat (n) send_beat(1'b0, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) send_beat(1'b1, 8'($urandom_range(0, 255)));
        else send_beat(1'b0, ssplit_pkg::CH_NL);
      end else if (pick < 70) begin
        // block comment, now and then left open at end of text
        send_beat(1'b0, ssplit_pkg::CH_SLASH);
        send_beat(1'b0, ssplit_pkg::CH_STAR);
        n = $urandom_range(0, 8);
        repeat (n) begin
          c = ($urandom_range(0, 3) == 0) ? ssplit_pkg::CH_STAR : 8'($urandom_range(0, 255));
          send_beat(1'b0, c);
        end
        if ($urandom_range(0, 3) == 0) begin
          send_beat(1'b1, 8'($urandom_range(0, 255)));
        end else begin
          send_beat(1'b0, ssplit_pkg::CH_STAR);
          send_beat(1'b0, ssplit_pkg::CH_SLASH);
        end
      end else if (pick < 80) begin
        send_beat(1'b0, ssplit_pkg::CH_SEMI);
      end else if (pick < 86) begin
        // lone dash or slash that opens nothing
        send_beat(1'b0, ($urandom_range(0, 1) == 0) ? ssplit_pkg::CH_DASH : ssplit_pkg::CH_SLASH);
      end else if (pick < 90) begin
        send_beat(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(1'b0, 8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;

    drain_wait();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
